### sv/ntc_pkg.sv
package ntc_pkg;

  localparam int TABLE_POINTS = 12;
  localparam int ADC_BITS     = 10;
  localparam int OFFSET_W     = 13;
  localparam int STEP_W       = 10;
  localparam int TEMP_W       = 16;
  localparam int SEG_W        = $clog2(TABLE_POINTS);
  localparam int NUM_W        = ADC_BITS + STEP_W;
  localparam int DCNT_W       = $clog2(STEP_W + 1);
  localparam int IN_TDATA_W   = ((ADC_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((TEMP_W + 7) / 8) * 8;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = OFFSET_W;

  localparam logic [TEMP_W-1:0]   OOR_CODE     = TEMP_W'(-32767);
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(-200);
  localparam logic [STEP_W-1:0]   STEP_RESET   = STEP_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_OFFSET = 1'b0,
    CFG_TEMP_STEP   = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MULT,
    ST_DIV,
    ST_DONE
  } st_t;

  // Calibration points, strictly descending.
  function automatic logic [ADC_BITS-1:0] cal_rom(input logic [SEG_W-1:0] idx);
    logic [ADC_BITS-1:0] v;
    v = '0;
    unique case (idx)
      4'd0:    v = ADC_BITS'(929);
      4'd1:    v = ADC_BITS'(869);
      4'd2:    v = ADC_BITS'(787);
      4'd3:    v = ADC_BITS'(685);
      4'd4:    v = ADC_BITS'(573);
      4'd5:    v = ADC_BITS'(461);
      4'd6:    v = ADC_BITS'(359);
      4'd7:    v = ADC_BITS'(274);
      4'd8:    v = ADC_BITS'(206);
      4'd9:    v = ADC_BITS'(154);
      4'd10:   v = ADC_BITS'(116);
      4'd11:   v = ADC_BITS'(87);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### sv/ntc_div.sv
module ntc_div import ntc_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [NUM_W-1:0]    num,
  input  logic [ADC_BITS-1:0] den,
  output logic                done,
  output logic [STEP_W-1:0]   quo
);

  logic [ADC_BITS-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0]   quo_r, quo_nxt;
  logic [DCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [ADC_BITS:0]   trial;
  logic                ge;

  // The quotient is known to fit STEP_W bits, so the upper numerator bits
  // seed the remainder and only STEP_W restoring steps are needed.
  assign trial = {rem_r, quo_r[STEP_W-1]};
  assign ge    = (trial >= {1'b0, den});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = num[NUM_W-1:STEP_W];
      quo_nxt  = num[STEP_W-1:0];
      cnt_nxt  = DCNT_W'(STEP_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? ADC_BITS'(trial - {1'b0, den}) : trial[ADC_BITS-1:0];
      quo_nxt = {quo_r[STEP_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DCNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### sv/ntc_adc_to_temperature.sv
// Thermistor ADC sample to temperature in tenths of a degree.
//
// The input stream carries one ADC sample per item in in_tdata; the output
// stream returns one item per sample: the temperature in out_tdata and an
// out-of-range flag in out_tuser. Samples at or above the first calibration
// point or below the last one return the out-of-range code with the flag set.
//
// One item is handled at a time. A sequencer walks the calibration table
// one point per cycle, then a single multiply feeds a restoring divider
// that yields one quotient bit per cycle. An in-range sample falls in
// a segment from 1 to 11; out-of-range samples skip the multiply and divide.
// The next item can be accepted in the cycle after the result is loaded.
//
// in_tready is high only while the block is idle. The result sits in an
// output register until taken; if the receiver stalls, the next item still
// runs and waits in its final state for the register to free up.
// Reset clears the sequencer and output valid, sets offset -200, step 100.
// The user writes configuration only while idle; the block does not check.
module ntc_adc_to_temperature import ntc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [9:0] adc_value
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // [15:0] temp_tenths
  output logic                   out_tuser   // [0] out_of_range
);

  st_t state_r, state_nxt;

  logic [OFFSET_W-1:0] offset_r;
  logic [STEP_W-1:0]   step_r;
  logic [ADC_BITS-1:0] sample_r;
  logic [SEG_W-1:0]    seg_r;
  logic [TEMP_W-1:0]   base_r;
  logic [STEP_W-1:0]   frac_r;
  logic                oor_r;
  logic                out_valid_r;
  logic [TEMP_W-1:0]   out_temp_r;
  logic                out_oor_r;

  logic [ADC_BITS-1:0] rom_cur, rom_prev;
  logic [ADC_BITS-1:0] span;
  logic [ADC_BITS-1:0] diff;
  logic [NUM_W-1:0]    product;
  logic                below;
  logic                accept;
  logic                out_free;
  logic                div_start;
  logic                div_done;
  logic [STEP_W-1:0]   div_quo;

  assign rom_cur  = cal_rom(seg_r);
  assign rom_prev = cal_rom(seg_r - 1'b1);
  assign span     = rom_prev - rom_cur;
  assign diff     = rom_prev - sample_r;
  assign product  = NUM_W'(diff * step_r);
  assign below    = (sample_r < rom_cur);
  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  ntc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (product),
    .den   (span),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_tvalid) state_nxt = ST_SEARCH;
      ST_SEARCH: begin
        if (!below) begin
          state_nxt = (seg_r == '0) ? ST_DONE : ST_MULT;
        end else if (seg_r == SEG_W'(TABLE_POINTS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_MULT:   state_nxt = ST_DIV;
      ST_DIV:    if (div_done) state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_MULT: div_start = 1'b1;
      default: begin
        in_tready = 1'b0;
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      offset_r    <= OFFSET_RESET;
      step_r      <= STEP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_TEMP_OFFSET: offset_r <= cfg_wdata[OFFSET_W-1:0];
          CFG_TEMP_STEP:   step_r   <= cfg_wdata[STEP_W-1:0];
          default:         offset_r <= offset_r;
        endcase
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath. base_r gathers offset + (seg - 1) * step during the walk.
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_tdata[ADC_BITS-1:0];
      seg_r    <= '0;
      base_r   <= {{(TEMP_W - OFFSET_W){offset_r[OFFSET_W-1]}}, offset_r};
      oor_r    <= 1'b0;
    end
    if (state_r == ST_SEARCH) begin
      if (below) begin
        if (seg_r == SEG_W'(TABLE_POINTS - 1)) begin
          oor_r <= 1'b1;
        end else begin
          seg_r <= seg_r + 1'b1;
          if (seg_r != '0) begin
            base_r <= base_r + {{(TEMP_W - STEP_W){1'b0}}, step_r};
          end
        end
      end else if (seg_r == '0) begin
        oor_r <= 1'b1;
      end
    end
    // A flat segment would make the fraction zero.
    if (state_r == ST_DIV && div_done) begin
      frac_r <= (span == '0) ? '0 : div_quo;
    end
    if (state_r == ST_DONE && out_free) begin
      out_oor_r  <= oor_r;
      out_temp_r <= oor_r ? OOR_CODE
                          : base_r + {{(TEMP_W - STEP_W){1'b0}}, frac_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_temp_r);
  assign out_tuser  = out_oor_r;

endmodule
